### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assert failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("assert failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

### rtl/fpsc_pkg.sv
// Types and constants for the farthest-point segment cover block.
`timescale 1ns / 1ps
package fpsc_pkg;
  localparam int COORD_BITS = 32;
  localparam int DIST_W = 34;
  localparam int NUM_REGS = 6;
  localparam logic [2:0] REG_SX = 3'd0;
  localparam logic [2:0] REG_SY = 3'd1;
  localparam logic [2:0] REG_SZ = 3'd2;
  localparam logic [2:0] REG_EX = 3'd3;
  localparam logic [2:0] REG_EY = 3'd4;
  localparam logic [2:0] REG_EZ = 3'd5;
  typedef enum logic [3:0] {
    ST_IDLE, ST_PROJ, ST_LEN, ST_DIV, ST_OFFS, ST_DIST, ST_SQRT, ST_UPD,
    ST_WALK_RD, ST_WALK_DIST, ST_WALK_SQRT, ST_WALK_CHK, ST_OUT
  } state_t;
endpackage

### rtl/fpsc_sqrt.sv
// Bit-serial floor square root, one result bit per cycle, saturated output.
`timescale 1ns / 1ps
module fpsc_sqrt #(
  parameter int IN_W = 102
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [IN_W-1:0]              radicand,
  output logic                         done,
  output logic [fpsc_pkg::DIST_W-1:0]  root
);
  localparam int RW = (IN_W + 1) / 2;
  localparam int CW = $clog2(RW + 1);
  localparam int QW = RW + fpsc_pkg::DIST_W;
  logic [IN_W+1:0] rem;
  logic [RW-1:0]   q;
  logic [2*RW-1:0] src;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic [IN_W+1:0] trial;
  logic [IN_W+1:0] rem_sh;
  logic [QW-1:0]   q_wide;

  always_comb begin
    rem_sh = {rem[IN_W-1:0], src[2*RW-1 -: 2]};
    trial = {{(IN_W + 2 - RW - 2){1'b0}}, q, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(RW);
        rem <= '0;
        q <= '0;
        src <= (2 * RW)'(radicand);
      end else if (busy) begin
        src <= src << 2;
        if (rem_sh >= trial) begin
          rem <= rem_sh - trial;
          q <= {q[RW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          q <= {q[RW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    q_wide = QW'(q);
    if (|(q_wide >> fpsc_pkg::DIST_W))
      root = '1;
    else
      root = q_wide[fpsc_pkg::DIST_W-1:0];
  end
endmodule

### rtl/farthest_point_from_segment_cover.sv
// Farthest point from a segment with cover check: top level.
// Per point, after the accepting beat: dot product, length, divide (cut short when t clamps),
// offsets, distance, square root and update; a new point is accepted only back in IDLE.
// The last point adds a walk over the stored points (ends at the first miss), then the
// result beat is sent; a waiting result stalls only OUT.
// Synchronous active-high reset clears control, counters and best-point state;
// stored points are undefined until written and configuration resets to zero.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module farthest_point_from_segment_cover #(
  parameter int MAX_POINTS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // point_x, point_y, point_z
  input  logic        s_axis_tlast,   // last_point
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // point_index[9:0], max_distance[43:10]
  output logic        m_axis_tuser,   // found
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [fpsc_pkg::COORD_BITS-1:0] cfg_data
);
  localparam int CW = fpsc_pkg::COORD_BITS;
  localparam int DW = CW + 1;             // difference width
  localparam int PW = 2 * DW;             // product width
  localparam int SW = PW + 2;             // sum of three
  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int DV = fpsc_pkg::DIST_W;

  logic signed [CW-1:0] seg [fpsc_pkg::NUM_REGS];
  logic signed [CW-1:0] mem_x [MAX_POINTS];
  logic signed [CW-1:0] mem_y [MAX_POINTS];
  logic signed [CW-1:0] mem_z [MAX_POINTS];
  logic signed [CW-1:0] rd_x, rd_y, rd_z;

  fpsc_pkg::state_t state, state_next;
  logic signed [CW-1:0] px, py, pz;
  logic signed [DW-1:0] dx, dy, dz, ax, ay, az;
  logic signed [CW-1:0] s0x, s0y, s0z;
  logic signed [SW-1:0] acc;          // running signed sum (dot or squares)
  logic        [SW-1:0] len2;
  logic        [1:0]    k;
  logic        [SW-1:0] rem;
  logic        [32:0]   t;
  logic        [5:0]    dcnt;
  logic signed [DW:0]   pj [3];
  logic signed [DW:0]   bp [3];
  logic        [DV-1:0] best_dist, cur_dist;
  logic        [AW-1:0] best_idx;
  logic                 best_valid;
  logic        [NW-1:0] count;
  logic        [NW-1:0] walk;
  logic                 is_last, fnd;
  logic                 sq_start, sq_done;
  logic        [DV-1:0] sq_root;
  logic signed [DW:0]   mul_a;
  logic signed [DW+1:0] mul_b;
  logic signed [2*DW+2:0] mul_p;
  logic                 out_free;

  assign s_axis_tready = (state == fpsc_pkg::ST_IDLE);
  assign cfg_ready = (state == fpsc_pkg::ST_IDLE);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      fpsc_pkg::ST_PROJ: begin
        case (k)
          2'd0: begin mul_a = (DW+1)'(dx); mul_b = (DW+2)'(ax); end
          2'd1: begin mul_a = (DW+1)'(dy); mul_b = (DW+2)'(ay); end
          default: begin mul_a = (DW+1)'(dz); mul_b = (DW+2)'(az); end
        endcase
      end
      fpsc_pkg::ST_LEN: begin
        case (k)
          2'd0: begin mul_a = (DW+1)'(dx); mul_b = (DW+2)'(dx); end
          2'd1: begin mul_a = (DW+1)'(dy); mul_b = (DW+2)'(dy); end
          default: begin mul_a = (DW+1)'(dz); mul_b = (DW+2)'(dz); end
        endcase
      end
      fpsc_pkg::ST_OFFS: begin
        case (k)
          2'd0: mul_a = (DW+1)'(dx);
          2'd1: mul_a = (DW+1)'(dy);
          default: mul_a = (DW+1)'(dz);
        endcase
        mul_b = $signed({1'b0, (DW+1)'(t)});
      end
      fpsc_pkg::ST_DIST, fpsc_pkg::ST_WALK_DIST: begin
        case (k)
          2'd0: begin mul_a = (state == fpsc_pkg::ST_DIST) ? pj[0] - (DW+1)'(px)
                                                           : bp[0] - (DW+1)'(rd_x); end
          2'd1: begin mul_a = (state == fpsc_pkg::ST_DIST) ? pj[1] - (DW+1)'(py)
                                                           : bp[1] - (DW+1)'(rd_y); end
          default: begin mul_a = (state == fpsc_pkg::ST_DIST) ? pj[2] - (DW+1)'(pz)
                                                              : bp[2] - (DW+1)'(rd_z); end
        endcase
        mul_b = (DW+2)'(mul_a);
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  logic [SW-1:0] rem_sh;
  assign rem_sh = {rem[SW-2:0], 1'b0};

  logic signed [DW+1:0] off_r;
  assign off_r = (DW+2)'((mul_p + (2*DW+3)'(33'sh80000000)) >>> 32);

  // magnitude rounding for negative direction: round(|d|*t) with |d| = -d
  function automatic logic signed [DW+1:0] off_r_neg(input logic signed [2*DW+2:0] p);
    logic signed [2*DW+2:0] m;
    m = -p;
    off_r_neg = (DW+2)'((m + (2*DW+3)'(33'sh80000000)) >>> 32);
    off_r_neg = -off_r_neg;
  endfunction

  fpsc_sqrt #(.IN_W(SW)) u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(acc[SW-1:0]),
    .done(sq_done), .root(sq_root)
  );

  always_comb begin
    state_next = state;
    case (state)
      fpsc_pkg::ST_IDLE:
        if (s_axis_tvalid && s_axis_tready) state_next = fpsc_pkg::ST_PROJ;
      fpsc_pkg::ST_PROJ:
        if (k == 2'd3) state_next = fpsc_pkg::ST_LEN;
      fpsc_pkg::ST_LEN:
        if (k == 2'd3) state_next = fpsc_pkg::ST_DIV;
      fpsc_pkg::ST_DIV:
        if (dcnt == 6'd0) state_next = fpsc_pkg::ST_OFFS;
      fpsc_pkg::ST_OFFS:
        if (k == 2'd2) state_next = fpsc_pkg::ST_DIST;
      fpsc_pkg::ST_DIST:
        if (k == 2'd3) state_next = fpsc_pkg::ST_SQRT;
      fpsc_pkg::ST_SQRT:
        if (sq_done) state_next = fpsc_pkg::ST_UPD;
      fpsc_pkg::ST_UPD:
        state_next = is_last ? fpsc_pkg::ST_WALK_RD : fpsc_pkg::ST_IDLE;
      fpsc_pkg::ST_WALK_RD:
        state_next = (!fnd || walk >= count) ? fpsc_pkg::ST_OUT : fpsc_pkg::ST_WALK_DIST;
      fpsc_pkg::ST_WALK_DIST:
        if (k == 2'd3) state_next = fpsc_pkg::ST_WALK_SQRT;
      fpsc_pkg::ST_WALK_SQRT:
        if (sq_done) state_next = fpsc_pkg::ST_WALK_CHK;
      fpsc_pkg::ST_WALK_CHK:
        state_next = fpsc_pkg::ST_WALK_RD;
      fpsc_pkg::ST_OUT:
        if (out_free) state_next = fpsc_pkg::ST_IDLE;
      default: state_next = fpsc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    sq_start = ((state == fpsc_pkg::ST_DIST) || (state == fpsc_pkg::ST_WALK_DIST))
               && (k == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready && count < NW'(MAX_POINTS)) begin
      mem_x[count[AW-1:0]] <= CW'(s_axis_tdata[31:0]);
      mem_y[count[AW-1:0]] <= CW'(s_axis_tdata[63:32]);
      mem_z[count[AW-1:0]] <= CW'(s_axis_tdata[95:64]);
    end
    if (state == fpsc_pkg::ST_WALK_RD) begin
      rd_x <= mem_x[walk[AW-1:0]];
      rd_y <= mem_y[walk[AW-1:0]];
      rd_z <= mem_z[walk[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpsc_pkg::ST_IDLE;
      for (int i = 0; i < fpsc_pkg::NUM_REGS; i++) seg[i] <= '0;
      count <= '0;
      best_dist <= '0;
      best_idx <= '0;
      best_valid <= 1'b0;
      for (int i = 0; i < 3; i++) bp[i] <= '0;
      m_axis_tvalid <= 1'b0;
      k <= '0;
    end else begin
      state <= state_next;
      if (state == fpsc_pkg::ST_OUT && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (cfg_valid && cfg_ready && cfg_index < 3'(fpsc_pkg::NUM_REGS))
        seg[cfg_index] <= cfg_data;
      case (state)
        fpsc_pkg::ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            px <= CW'(s_axis_tdata[31:0]);
            py <= CW'(s_axis_tdata[63:32]);
            pz <= CW'(s_axis_tdata[95:64]);
            is_last <= s_axis_tlast;
            s0x <= seg[fpsc_pkg::REG_SX];
            s0y <= seg[fpsc_pkg::REG_SY];
            s0z <= seg[fpsc_pkg::REG_SZ];
            dx <= DW'(seg[fpsc_pkg::REG_EX]) - DW'(seg[fpsc_pkg::REG_SX]);
            dy <= DW'(seg[fpsc_pkg::REG_EY]) - DW'(seg[fpsc_pkg::REG_SY]);
            dz <= DW'(seg[fpsc_pkg::REG_EZ]) - DW'(seg[fpsc_pkg::REG_SZ]);
            ax <= DW'(signed'(CW'(s_axis_tdata[31:0]))) - DW'(seg[fpsc_pkg::REG_SX]);
            ay <= DW'(signed'(CW'(s_axis_tdata[63:32]))) - DW'(seg[fpsc_pkg::REG_SY]);
            az <= DW'(signed'(CW'(s_axis_tdata[95:64]))) - DW'(seg[fpsc_pkg::REG_SZ]);
            acc <= '0;
            len2 <= '0;
            k <= '0;
          end
        end
        fpsc_pkg::ST_PROJ: begin
          // dot product on the shared multiplier
          if (k != 2'd3) begin
            acc <= acc + SW'(mul_p);
            k <= k + 1'b1;
          end else k <= '0;
        end
        fpsc_pkg::ST_LEN: begin
          if (k != 2'd3) begin
            len2 <= len2 + SW'(mul_p);
            k <= k + 1'b1;
          end else begin
            k <= '0;
            dcnt <= 6'd32;
            rem <= acc;
            t <= '0;
          end
        end
        fpsc_pkg::ST_DIV: begin
          if (len2 == '0 || acc[SW-1] || acc == '0) begin
            t <= '0;
            dcnt <= '0;
          end else if (acc >= signed'(len2)) begin
            t <= 33'h1_0000_0000;
            dcnt <= '0;
          end else if (dcnt != 6'd0) begin
            if (rem_sh >= len2) begin
              rem <= rem_sh - len2;
              t <= {t[31:0], 1'b1};
            end else begin
              rem <= rem_sh;
              t <= {t[31:0], 1'b0};
            end
            dcnt <= dcnt - 1'b1;
          end
        end
        fpsc_pkg::ST_OFFS: begin
          // offset = sign(d)*round(|d|*t), same as rounding half away from zero
          case (k)
            2'd0: pj[0] <= (DW+1)'(s0x) + (dx[DW-1] ? -(DW+1)'(-off_r_neg(mul_p)) : (DW+1)'(off_r));
            2'd1: pj[1] <= (DW+1)'(s0y) + (dy[DW-1] ? -(DW+1)'(-off_r_neg(mul_p)) : (DW+1)'(off_r));
            default: pj[2] <= (DW+1)'(s0z) + (dz[DW-1] ? -(DW+1)'(-off_r_neg(mul_p)) : (DW+1)'(off_r));
          endcase
          if (k == 2'd2) begin
            k <= '0;
            acc <= '0;
          end else k <= k + 1'b1;
        end
        fpsc_pkg::ST_DIST, fpsc_pkg::ST_WALK_DIST: begin
          if (k != 2'd3) begin
            acc <= acc + SW'(mul_p);
            k <= k + 1'b1;
          end else k <= '0;
        end
        fpsc_pkg::ST_SQRT: if (sq_done) cur_dist <= sq_root;
        fpsc_pkg::ST_WALK_SQRT: if (sq_done) cur_dist <= sq_root;
        fpsc_pkg::ST_UPD: begin
          if (count < NW'(MAX_POINTS)) begin
            if (cur_dist > best_dist) begin
              best_dist <= cur_dist;
              best_idx <= count[AW-1:0];
              best_valid <= 1'b1;
              bp[0] <= pj[0];
              bp[1] <= pj[1];
              bp[2] <= pj[2];
            end
            count <= count + 1'b1;
          end
          walk <= '0;
          fnd <= best_valid || (count < NW'(MAX_POINTS) && cur_dist > best_dist);
        end
        fpsc_pkg::ST_WALK_RD: begin
          acc <= '0;
          k <= '0;
        end
        fpsc_pkg::ST_WALK_CHK: begin
          if (cur_dist > best_dist) fnd <= 1'b0;
          walk <= walk + 1'b1;
        end
        fpsc_pkg::ST_OUT: begin
          if (out_free) begin
            m_axis_tuser <= fnd;
            m_axis_tdata <= fnd ? {4'd0, best_dist, 10'(best_idx)} : '0;
            count <= '0;
            best_dist <= '0;
            best_idx <= '0;
            best_valid <= 1'b0;
            for (int i = 0; i < 3; i++) bp[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_NEXT(a_out_after_done, clk, rst, state == fpsc_pkg::ST_OUT, m_axis_tvalid)
  `ASSERT_IMPL(a_no_accept_busy, clk, rst, (state != fpsc_pkg::ST_IDLE) |-> !s_axis_tready)
  `ASSERT_IMPL(a_count_bound, clk, rst, count <= NW'(MAX_POINTS))
  `ASSERT_IMPL(a_best_valid_dist, clk, rst, !best_valid |-> (best_dist == '0))
endmodule
